>>> rtl/core/bcps_pkg.sv
// Shared types and constants for the bit-sliced column predicate scan.
// Holds request payload structs, configuration struct and register codes.
// No dependencies.
`default_nettype none

package bcps_pkg;

  localparam int unsigned MAX_CODE_WIDTH_DEF = 32;
  localparam int unsigned LANES_DEF          = 64;
  localparam int unsigned WORD_W             = 64;
  localparam int unsigned LIT_W              = 32;
  localparam int unsigned POS_W              = 6;
  localparam int unsigned CFG_ADDR_W         = 5;
  localparam int unsigned CFG_DATA_W         = 32;

  typedef enum logic [2:0] {
    REG_CMP_MODE    = 3'd0,
    REG_COMB_MODE   = 3'd1,
    REG_LITERAL_A   = 3'd2,
    REG_LITERAL_B   = 3'd3,
    REG_CODE_WIDTH  = 3'd4,
    REG_CMP_SOURCE  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMP_EQ      = 3'd0,
    CMP_NE      = 3'd1,
    CMP_GT      = 3'd2,
    CMP_LT      = 3'd3,
    CMP_GE      = 3'd4,
    CMP_LE      = 3'd5,
    CMP_BETWEEN = 3'd6
  } cmp_mode_t;

  typedef enum logic [1:0] {
    COMB_SET = 2'd0,
    COMB_AND = 2'd1,
    COMB_OR  = 2'd2
  } comb_mode_t;

  typedef struct packed {
    logic [2:0]       comparison_mode;
    logic [1:0]       combine_mode;
    logic [LIT_W-1:0] literal_a;
    logic [LIT_W-1:0] literal_b;
    logic [5:0]       code_width;
    logic             compare_source;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] slice_word;
    logic [WORD_W-1:0] other_slice_word;
    logic [WORD_W-1:0] prior_vector_word;
    logic              final_segment;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic              final_segment_out;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/core/bitsliced_column_predicate_scan.sv
// Top level of the bit-sliced column predicate scan.
// Instantiates bcps_cfg and bcps_slice; depends on bcps_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): one slice word per request,
//   most significant slice first, code_width requests per segment of codes.
//   Result channel (out_valid, out_stall, out_data): one result word per
//   segment, produced by the segment's last slice request.
//   Configuration: APB-style port, registers at byte address 4*i; write it
//   only while no request is in flight.
// Flow: an accepted request waits in the input register and is folded into the
//   masks when it advances; for a last slice the result is registered at that
//   same edge and out_valid is high from then on.
// Throughput: one slice request per cycle unless a held last slice stalls the
//   input; the mask update between the input and result registers is combinational.
// Reset: rst_n (synchronous) empties both registers, clears the slice count
//   and masks and restores register defaults (code_width 1).
// Stall: while out_stall holds a pending result, the next last-slice request
//   waits in the input register; non-final slices keep flowing. Once the
//   input register is held, in_stall rises.
`default_nettype none

module bitsliced_column_predicate_scan #(
  parameter int unsigned MAX_CODE_WIDTH = bcps_pkg::MAX_CODE_WIDTH_DEF,
  parameter int unsigned LANES          = bcps_pkg::LANES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire bcps_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output bcps_pkg::out_t                        out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bcps_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [bcps_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [bcps_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);

  bcps_pkg::cfg_t cfg;
  bcps_pkg::in_t  in_r;
  bcps_pkg::out_t out_r, rsp;
  logic           in_vld_r, in_vld_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic           last, adv, in_acc, out_acc;

  bcps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcps_slice #(
    .MAX_CODE_WIDTH (MAX_CODE_WIDTH),
    .LANES          (LANES)
  ) u_slice (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .req   (in_r),
    .fire  (adv),
    .last  (last),
    .rsp   (rsp)
  );

  assign out_acc  = out_vld_r && !out_stall;
  assign adv      = in_vld_r && (!last || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    in_vld_nxt = in_acc || (in_vld_r && !adv);
    if (adv && last) begin
      out_vld_nxt = 1'b1;
    end else if (out_acc) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (adv && last) begin
      out_r <= rsp;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |-> !(adv && last))
    else $error("pending result overwritten");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(adv && last))
    else $error("result appeared without a last slice");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && last && out_vld_r)
    else $error("input stalled with no blocking result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bcps_cfg.sv
// Configuration register file with APB-style access.
// Depends on bcps_pkg for the register codes and cfg_t.
`default_nettype none

module bcps_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bcps_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [bcps_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [bcps_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output bcps_pkg::cfg_t                        cfg
);

  bcps_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.comparison_mode <= '0;
      cfg_r.combine_mode    <= '0;
      cfg_r.literal_a       <= '0;
      cfg_r.literal_b       <= '0;
      cfg_r.code_width      <= 6'd1;
      cfg_r.compare_source  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        bcps_pkg::REG_CMP_MODE:   cfg_r.comparison_mode <= pwdata[2:0];
        bcps_pkg::REG_COMB_MODE:  cfg_r.combine_mode    <= pwdata[1:0];
        bcps_pkg::REG_LITERAL_A:  cfg_r.literal_a       <= pwdata;
        bcps_pkg::REG_LITERAL_B:  cfg_r.literal_b       <= pwdata;
        bcps_pkg::REG_CODE_WIDTH: cfg_r.code_width      <= pwdata[5:0];
        bcps_pkg::REG_CMP_SOURCE: cfg_r.compare_source  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bcps_pkg::REG_CMP_MODE:   prdata = 32'(cfg_r.comparison_mode);
      bcps_pkg::REG_COMB_MODE:  prdata = 32'(cfg_r.combine_mode);
      bcps_pkg::REG_LITERAL_A:  prdata = cfg_r.literal_a;
      bcps_pkg::REG_LITERAL_B:  prdata = cfg_r.literal_b;
      bcps_pkg::REG_CODE_WIDTH: prdata = 32'(cfg_r.code_width);
      bcps_pkg::REG_CMP_SOURCE: prdata = 32'(cfg_r.compare_source);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/bcps_slice.sv
// Per-slice compare unit: holds the equal/less/greater masks and slice count,
// folds one slice word per cycle while fire is high and forms the result word on the last slice.
// Depends on bcps_pkg.
`default_nettype none

module bcps_slice #(
  parameter int unsigned MAX_CODE_WIDTH = bcps_pkg::MAX_CODE_WIDTH_DEF,
  parameter int unsigned LANES          = bcps_pkg::LANES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bcps_pkg::cfg_t cfg,
  input  wire bcps_pkg::in_t  req,
  input  wire logic           fire,
  output logic                last,
  output bcps_pkg::out_t      rsp
);

  localparam int unsigned IDX_W = (MAX_CODE_WIDTH > 1) ? $clog2(MAX_CODE_WIDTH) : 1;
  localparam int unsigned W_W   = $clog2(MAX_CODE_WIDTH + 1);

  logic [IDX_W-1:0] slice_index_r, slice_index_nxt;
  logic [LANES-1:0] eql_r, eql_nxt, eqh_r, eqh_nxt;
  logic [LANES-1:0] lt_r, lt_nxt, gt_r, gt_nxt;
  logic [LANES-1:0] saved_r, saved_nxt;

  logic                     first;
  logic [W_W-1:0]           w, idx0, idx, idx_inc;
  logic [bcps_pkg::POS_W-1:0] pos;
  logic [LANES-1:0]         d, other, prior, seed;
  logic [LANES-1:0]         eql_b, eqh_b, lt_b, gt_b;
  logic [LANES-1:0]         l1, l2, o, mask, res;
  logic                     bit_a, bit_b;

  always_comb begin
    if (cfg.code_width == 6'd0) begin
      w = W_W'(1);
    end else if (7'(cfg.code_width) > 7'(MAX_CODE_WIDTH)) begin
      w = W_W'(MAX_CODE_WIDTH);
    end else begin
      w = W_W'(cfg.code_width);
    end

    d     = req.slice_word[LANES-1:0];
    other = req.other_slice_word[LANES-1:0];
    prior = req.prior_vector_word[LANES-1:0];
    first = (slice_index_r == '0);

    unique case (cfg.combine_mode)
      bcps_pkg::COMB_AND: seed = prior;
      bcps_pkg::COMB_OR:  seed = ~prior;
      default:            seed = '1;
    endcase

    eql_b     = first ? seed : eql_r;
    eqh_b     = first ? seed : eqh_r;
    lt_b      = first ? '0 : lt_r;
    gt_b      = first ? '0 : gt_r;
    saved_nxt = first ? prior : saved_r;

    idx0    = W_W'(slice_index_r);
    idx     = (idx0 >= w) ? (w - W_W'(1)) : idx0;
    idx_inc = idx + W_W'(1);
    pos     = bcps_pkg::POS_W'(w - W_W'(1) - idx);

    bit_a = (pos < 6'd32) ? cfg.literal_a[pos[4:0]] : 1'b0;
    bit_b = (pos < 6'd32) ? cfg.literal_b[pos[4:0]] : 1'b0;
    l1    = {LANES{bit_a}};
    l2    = {LANES{bit_b}};
    o     = cfg.compare_source ? other : l1;

    if (cfg.comparison_mode == bcps_pkg::CMP_BETWEEN) begin
      lt_nxt  = lt_b | (eqh_b & ~d & l2);
      gt_nxt  = gt_b | (eql_b & d & ~l1);
      eql_nxt = eql_b & ~(d ^ l1);
      eqh_nxt = eqh_b & ~(d ^ l2);
    end else begin
      lt_nxt  = lt_b | (eql_b & ~d & o);
      gt_nxt  = gt_b | (eql_b & d & ~o);
      eql_nxt = eql_b & ~(d ^ o);
      eqh_nxt = eqh_b;
    end

    last            = (idx_inc >= w);
    slice_index_nxt = last ? '0 : IDX_W'(idx_inc);

    unique case (cfg.comparison_mode)
      bcps_pkg::CMP_NE:      mask = ~eql_nxt;
      bcps_pkg::CMP_GT:      mask = gt_nxt;
      bcps_pkg::CMP_LT:      mask = lt_nxt;
      bcps_pkg::CMP_GE:      mask = gt_nxt | eql_nxt;
      bcps_pkg::CMP_LE:      mask = lt_nxt | eql_nxt;
      bcps_pkg::CMP_BETWEEN: mask = (lt_nxt | eqh_nxt) & (eql_nxt | gt_nxt);
      default:               mask = eql_nxt;
    endcase

    unique case (cfg.combine_mode)
      bcps_pkg::COMB_AND: res = mask & saved_nxt;
      bcps_pkg::COMB_OR:  res = mask | saved_nxt;
      default:            res = mask;
    endcase

    rsp.result_word       = bcps_pkg::WORD_W'(res);
    rsp.final_segment_out = req.final_segment;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_index_r <= '0;
      eql_r         <= '0;
      eqh_r         <= '0;
      lt_r          <= '0;
      gt_r          <= '0;
      saved_r       <= '0;
    end else if (fire) begin
      slice_index_r <= slice_index_nxt;
      eql_r         <= eql_nxt;
      eqh_r         <= eqh_nxt;
      lt_r          <= lt_nxt;
      gt_r          <= gt_nxt;
      saved_r       <= saved_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slice_index_r) < MAX_CODE_WIDTH)
    else $error("slice index out of range");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> slice_index_r == '0)
    else $error("slice index not cleared after last slice");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(slice_index_r) && $stable(eql_r))
    else $error("state changed without a slice");
`endif

endmodule

`default_nettype wire

>>> sim/tb_bitsliced_column_predicate_scan.sv
// Self-checking testbench for bitsliced_column_predicate_scan: directed and random
// slice streams are checked against a mask predictor kept in step with each request.
// Depends on bcps_pkg and the RTL top level only.

module tb_bitsliced_column_predicate_scan;
  import bcps_pkg::*;

  localparam logic [2:0]  CMP_UNUSED   = 3'd7;
  localparam logic [1:0]  COMB_UNUSED  = 2'd3;
  localparam int unsigned ITEMS_TARGET = 1650;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned SETTLE       = 4;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // register copy
  logic [2:0]  cmp_mode;
  logic [1:0]  comb_mode;
  logic [31:0] lit_a;
  logic [31:0] lit_b;
  logic [5:0]  code_w;
  logic        cmp_src;

  // scan state
  int unsigned slice_pos;
  logic [63:0] eq_lo_mask;
  logic [63:0] eq_hi_mask;
  logic [63:0] lt_mask;
  logic [63:0] gt_mask;
  logic [63:0] seg_prior;

  out_t        pending_results[$];
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          tx_idle;
  bit          rx_idle;
  int unsigned rx_hold_len;

  bitsliced_column_predicate_scan i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_width();
    if (code_w == 0) return 1;
    if (code_w > MAX_CODE_WIDTH_DEF) return MAX_CODE_WIDTH_DEF;
    return 32'(code_w);
  endfunction

  function automatic logic [63:0] lit_slice(logic [31:0] lit, int unsigned w,
                                            int unsigned pos);
    if (pos >= w) return '0;
    return {64{lit[w-1-pos]}};
  endfunction

  function automatic void predict_scan_slice(in_t req);
    int unsigned w;
    int unsigned pos;
    logic [63:0] d;
    logic [63:0] o;
    logic [63:0] la;
    logic [63:0] lb;
    logic [63:0] sel;
    out_t res;
    w = eff_width();
    d = req.slice_word;
    pos = slice_pos;
    if (pos == 0) begin
      case (comb_mode)
        COMB_AND: eq_lo_mask = req.prior_vector_word;
        COMB_OR:  eq_lo_mask = ~req.prior_vector_word;
        default:  eq_lo_mask = '1;
      endcase
      eq_hi_mask = eq_lo_mask;
      lt_mask = '0;
      gt_mask = '0;
      seg_prior = req.prior_vector_word;
    end
    if (pos >= w) pos = w - 1;
    if (cmp_mode == CMP_BETWEEN) begin
      la = lit_slice(lit_a, w, pos);
      lb = lit_slice(lit_b, w, pos);
      lt_mask |= eq_hi_mask & ~d & lb;
      gt_mask |= eq_lo_mask & d & ~la;
      eq_lo_mask &= ~(d ^ la);
      eq_hi_mask &= ~(d ^ lb);
    end else begin
      o = cmp_src ? req.other_slice_word : lit_slice(lit_a, w, pos);
      lt_mask |= eq_lo_mask & ~d & o;
      gt_mask |= eq_lo_mask & d & ~o;
      eq_lo_mask &= ~(d ^ o);
    end
    if (pos + 1 < w) begin
      slice_pos = pos + 1;
      return;
    end
    slice_pos = 0;
    case (cmp_mode)
      CMP_NE:      sel = ~eq_lo_mask;
      CMP_GT:      sel = gt_mask;
      CMP_LT:      sel = lt_mask;
      CMP_GE:      sel = gt_mask | eq_lo_mask;
      CMP_LE:      sel = lt_mask | eq_lo_mask;
      CMP_BETWEEN: sel = (lt_mask | eq_hi_mask) & (eq_lo_mask | gt_mask);
      default:     sel = eq_lo_mask;
    endcase
    case (comb_mode)
      COMB_AND: res.result_word = sel & seg_prior;
      COMB_OR:  res.result_word = sel | seg_prior;
      default:  res.result_word = sel;
    endcase
    res.final_segment_out = req.final_segment;
    pending_results.push_back(res);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic send_slice(logic [63:0] d, logic [63:0] od, logic [63:0] prior,
                            logic fin);
    int unsigned gap;
    in_t req;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    req.slice_word = d;
    req.other_slice_word = od;
    req.prior_vector_word = prior;
    req.final_segment = fin;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    predict_scan_slice(req);
    items_sent++;
  endtask

  task automatic cfg_write(reg_idx_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_CMP_MODE:   cmp_mode = v[2:0];
      REG_COMB_MODE:  comb_mode = v[1:0];
      REG_LITERAL_A:  lit_a = v;
      REG_LITERAL_B:  lit_b = v;
      REG_CODE_WIDTH: code_w = v[5:0];
      REG_CMP_SOURCE: cmp_src = v[0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // sender pauses until every expected result is back, then lets the block settle
  task automatic drain_scan();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] noise_bits();
    return ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
  endfunction

  function automatic logic [31:0] pick_literal();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // lanes hold codes near the literals so equal prefixes run deep
  task automatic send_segment(int unsigned n_slices, logic fin);
    logic [31:0] codes [64];
    logic [31:0] other [64];
    logic [63:0] d;
    logic [63:0] od;
    logic [63:0] prior;
    int unsigned w;
    w = eff_width();
    for (int l = 0; l < 64; l++) begin
      case ($urandom_range(0, 4))
        0: codes[l] = lit_a;
        1: codes[l] = lit_b;
        2: codes[l] = lit_a ^ (32'd1 << $urandom_range(0, w - 1));
        3: codes[l] = lit_b ^ (32'd1 << $urandom_range(0, w - 1));
        default: codes[l] = $urandom;
      endcase
      case ($urandom_range(0, 2))
        0: other[l] = codes[l];
        1: other[l] = codes[l] ^ (32'd1 << $urandom_range(0, w - 1));
        default: other[l] = $urandom;
      endcase
    end
    prior = {$urandom, $urandom};
    for (int s = 0; s < n_slices; s++) begin
      for (int l = 0; l < 64; l++) begin
        d[l] = codes[l][w-1-s];
        od[l] = other[l][w-1-s];
      end
      send_slice(d, od, (s == 0) ? prior : {$urandom, $urandom},
                 (s == n_slices - 1) ? fin : 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_reset_defaults();
    send_slice(64'h0, '1, 64'hFFFF_0000_FFFF_0000, 1'b0);
    send_slice('1, 64'h0, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1);
  endtask

  // lanes cycle through codes 3,2,1,0 at width 2; literals carry high junk bits
  task automatic test_each_mode();
    logic [1:0] combs [4];
    combs = '{COMB_SET, COMB_AND, COMB_OR, COMB_UNUSED};
    drain_scan();
    cfg_write(REG_CODE_WIDTH, 32'd2);
    cfg_write(REG_LITERAL_A, 32'hFFFF_FFFD);
    cfg_write(REG_LITERAL_B, 32'hFFFF_FFFE);
    for (int m = CMP_EQ; m <= CMP_UNUSED; m++) begin
      drain_scan();
      cfg_write(REG_CMP_MODE, m);
      cfg_write(REG_COMB_MODE, combs[m % 4]);
      send_slice(64'h3333_3333_3333_3333, '0, {$urandom, $urandom}, 1'(m % 2));
      send_slice(64'h5555_5555_5555_5555, '1, {$urandom, $urandom}, 1'(m % 2));
    end
  endtask

  task automatic test_column_source();
    drain_scan();
    cfg_write(REG_CMP_SOURCE, 32'd1);
    cfg_write(REG_CMP_MODE, CMP_LT);
    cfg_write(REG_COMB_MODE, COMB_OR);
    send_segment(2, 1'b1);
    drain_scan();
    // between ignores the column source
    cfg_write(REG_CMP_MODE, CMP_BETWEEN);
    send_segment(2, 1'b0);
  endtask

  task automatic test_width_edges();
    drain_scan();
    cfg_write(REG_CMP_SOURCE, 32'd0);
    cfg_write(REG_CODE_WIDTH, 32'd0);
    send_segment(1, 1'b1);
    drain_scan();
    cfg_write(REG_CODE_WIDTH, 32'd3);
    send_segment(2, 1'b0);
    drain_scan();
    // fewer slices left than already taken: next slice closes the segment
    cfg_write(REG_CODE_WIDTH, 32'd1);
    send_segment(1, 1'b1);
  endtask

  task automatic test_backpressure();
    drain_scan();
    cfg_write(REG_CMP_MODE, CMP_GE);
    tx_idle = 1'b0;
    rx_hold_len = 300;
    for (int i = 0; i < 40; i++) send_segment(1, 1'($urandom_range(0, 1)));
    drain_scan();
  endtask

  task automatic test_random_scan();
    int unsigned n_seg;
    int unsigned w;
    logic [5:0] cw;
    bit cut;
    while (items_sent < ITEMS_TARGET) begin
      drain_scan();
      cfg_write(REG_CMP_MODE,
                {29'(noise_bits() >> 3), 3'($urandom_range(CMP_UNUSED, CMP_EQ))});
      cfg_write(REG_COMB_MODE,
                {30'(noise_bits() >> 2), 2'($urandom_range(COMB_UNUSED, COMB_SET))});
      cfg_write(REG_LITERAL_A, pick_literal());
      cfg_write(REG_LITERAL_B, pick_literal());
      case ($urandom_range(0, 19))
        12, 13, 14, 15: cw = 6'($urandom_range(5, 8));
        16: cw = 6'($urandom_range(9, 31));
        17: cw = 6'd32;
        18: cw = 6'd0;
        19: cw = 6'($urandom_range(33, 63));
        default: cw = 6'($urandom_range(1, 4));
      endcase
      cfg_write(REG_CODE_WIDTH, {26'(noise_bits() >> 6), cw});
      cfg_write(REG_CMP_SOURCE, {31'(noise_bits() >> 1), 1'($urandom_range(0, 1))});
      tx_idle = $urandom_range(0, 2) != 0;
      rx_idle = $urandom_range(0, 2) != 0;
      w = eff_width();
      n_seg = $urandom_range(20, 60) / w + 1;
      cut = (w > 1) && ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n_seg; i++)
        send_segment((cut && i == n_seg - 1) ? $urandom_range(1, w - 1) : w,
                     1'($urandom_range(0, 1)));
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.result_word, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_word !== want.result_word)
          report_mismatch("result_word", out_data.result_word, want.result_word);
        if (out_data.final_segment_out !== want.final_segment_out)
          report_mismatch("final_segment_out", 64'(out_data.final_segment_out),
                          64'(want.final_segment_out));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_len != 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        n = rx_idle ? $urandom_range(0, 13) : 0;
      end
      repeat (n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cmp_mode = CMP_EQ;
    comb_mode = COMB_SET;
    lit_a = '0;
    lit_b = '0;
    code_w = 6'd1;
    cmp_src = 1'b0;
    slice_pos = 0;
    eq_lo_mask = '0;
    eq_hi_mask = '0;
    lt_mask = '0;
    gt_mask = '0;
    seg_prior = '0;
    err_count = 0;
    items_sent = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold_len = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_each_mode();
    test_column_source();
    test_width_edges();
    test_backpressure();
    test_random_scan();

    drain_scan();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
